// File: hw/rtl/eft_pkg.sv
// Package: shared types and constants for the event flag table
`timescale 1ns / 1ps
package eft_pkg;
  localparam int NUM_SLOTS_DEF = 8;

  localparam logic [2:0] OP_REQUEST = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_SET     = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_RELEASE = 3'd5;
  localparam logic [2:0] OP_EXIT    = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_NOSPC = 2'd2;
  localparam logic [1:0] ST_ACCES = 2'd3;

  localparam logic [8:0]  MODE_ALLOWED = 9'o666;
  localparam logic [14:0] ID_WRAP      = 15'd30000;
  localparam logic [31:0] ERR_VALUE    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         op;
    logic [14:0]        id_or_mode;
    logic signed [31:0] value;
    logic [14:0]        caller_pid;
    logic [14:0]        caller_group;
  } eft_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
  } eft_out_t;

  // Slot descriptor: id, mode, owner, group
  typedef struct packed {
    logic [14:0] id;
    logic [8:0]  mode;
    logic [14:0] owner;
    logic [14:0] group;
  } eft_desc_t;
endpackage

// File: hw/rtl/eft_flag_mem.sv
// Flag word memory: one write port, one registered read port
`timescale 1ns / 1ps
module eft_flag_mem #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                                                 clk,
  input  logic                                                 wr_en,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
  input  logic [31:0]                                          wr_data,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
  output logic [31:0]                                          rd_data
);
  logic [31:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: hw/rtl/eft_desc_mem.sv
// Slot descriptor memory: reset-cleared valid bits, registered read
`timescale 1ns / 1ps
module eft_desc_mem
  #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 wr_en,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
  input  eft_pkg::eft_desc_t                                   wr_data,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
  output eft_pkg::eft_desc_t                                   rd_data
);
  import eft_pkg::*;
  eft_desc_t mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;
  eft_desc_t rd_q;
  logic rd_vld_r;

  // Valid bits give the zero reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_q : '0;
endmodule

// File: hw/rtl/event_flag_table_core.sv
// Top level: event flag table sequencer
`timescale 1ns / 1ps
// Command-style block. Pulse start with in_data while busy is low; exactly
// one result appears on out_data with out_valid high for one cycle. The
// receiver cannot stall. Each transaction walks the slot descriptor memory
// one entry per cycle (registered read). Rejected commands, process exit and
// the invalid op go from the walk through S_ACT to S_DONE; successful read,
// write, set, clear and release add an S_FLAGS step, and every request
// starts with an S_IDADV step. The result is on the ports in the last busy
// cycle. A request repeats the id scan for each candidate id that is already
// in use, and takes an extra S_IDADV step when the counter wraps.
module event_flag_table_core #(
  parameter int NUM_SLOTS = eft_pkg::NUM_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  eft_pkg::eft_in_t in_data,
  output logic            out_valid,
  output eft_pkg::eft_out_t out_data
);
  import eft_pkg::*;
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS-1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_IDADV = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_FLAGS = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  eft_in_t req_r;
  logic [14:0] ctr_r, ctr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;     // read address issued
  logic rvld_r, rvld_nxt;              // read data valid this cycle
  logic [AW-1:0] raddr_r, raddr_nxt;   // address of data in flight
  logic hit_r, hit_nxt, clash_r, clash_nxt, free_r, free_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  eft_desc_t hit_desc_r, hit_desc_nxt;
  eft_out_t out_r, out_nxt;
  logic out_v_r, out_v_nxt;

  eft_desc_t d_rd, d_wdata;
  logic d_we;
  logic [AW-1:0] d_waddr;
  logic f_we;
  logic [AW-1:0] f_waddr;
  logic [31:0] f_wdata, f_rd;
  logic [31:0] bitmask;
  logic perm_ok;
  logic [14:0] ctr_inc;

  eft_desc_mem #(.NUM_SLOTS(NUM_SLOTS)) u_desc (
    .clk(clk), .rst_n(rst_n), .wr_en(d_we), .wr_addr(d_waddr),
    .wr_data(d_wdata), .rd_addr(addr_r), .rd_data(d_rd)
  );
  eft_flag_mem #(.NUM_SLOTS(NUM_SLOTS)) u_flag (
    .clk(clk), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
    .rd_addr(hit_idx_r), .rd_data(f_rd)
  );

  assign ctr_inc = ctr_r + 15'd1;
  assign bitmask = 32'd1 << req_r.value[4:0];

  // Permission check on the matched descriptor
  always_comb begin
    logic wr;
    wr = (req_r.op != OP_READ);
    if (hit_desc_r.owner == req_r.caller_pid) begin
      perm_ok = wr ? hit_desc_r.mode[7] : hit_desc_r.mode[8];
    end else if (hit_desc_r.group == req_r.caller_group) begin
      perm_ok = wr ? hit_desc_r.mode[4] : hit_desc_r.mode[5];
    end else begin
      perm_ok = wr ? hit_desc_r.mode[1] : hit_desc_r.mode[2];
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctr_nxt = ctr_r;
    addr_nxt = addr_r;
    rvld_nxt = 1'b0;
    raddr_nxt = addr_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    hit_desc_nxt = hit_desc_r;
    clash_nxt = clash_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    out_nxt = out_r;
    out_v_nxt = 1'b0;
    d_we = 1'b0;
    d_waddr = raddr_r;
    d_wdata = d_rd;
    f_we = 1'b0;
    f_waddr = hit_idx_r;
    f_wdata = f_rd;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          addr_nxt = '0;
          hit_nxt = 1'b0;
          clash_nxt = 1'b0;
          free_nxt = 1'b0;
          state_nxt = (in_data.op == OP_REQUEST) ? S_IDADV : S_SCAN;
          rvld_nxt = (in_data.op != OP_REQUEST);
          if (in_data.op != OP_REQUEST) begin
            addr_nxt = (NUM_SLOTS > 1) ? AW'(1) : '0;
          end
        end
      end
      S_IDADV: begin
        // Next candidate id, wrapping at the limit
        ctr_nxt = (ctr_inc >= ID_WRAP) ? 15'd1 : ctr_inc;
        if (ctr_inc < ID_WRAP) begin
          state_nxt = S_SCAN;
          clash_nxt = 1'b0;
          rvld_nxt = 1'b1;
          raddr_nxt = '0;
          addr_nxt = (NUM_SLOTS > 1) ? AW'(1) : '0;
        end
      end
      S_SCAN: begin
        if (rvld_r) begin
          if (req_r.op == OP_REQUEST) begin
            if (d_rd.id == ctr_r) clash_nxt = 1'b1;
            if (!free_r && d_rd.id == '0 && d_rd.mode == '0) begin
              free_nxt = 1'b1;
              free_idx_nxt = raddr_r;
            end
          end else if (req_r.op == OP_EXIT) begin
            if (d_rd.owner == req_r.caller_pid) begin
              d_we = 1'b1;
              d_wdata.id = '0;
              d_wdata.mode = '0;
            end
          end else if (d_rd.id == req_r.id_or_mode) begin
            hit_nxt = 1'b1;
            hit_idx_nxt = raddr_r;
            hit_desc_nxt = d_rd;
          end
          // Read address parks at entry 0 once the walk ends
          if (raddr_r == LAST) begin
            state_nxt = S_ACT;
            addr_nxt = '0;
          end else begin
            rvld_nxt = 1'b1;
            addr_nxt = (addr_r == LAST) ? '0 : addr_r + AW'(1);
          end
        end
      end
      S_ACT: begin
        state_nxt = S_DONE;
        out_nxt.status = ST_OK;
        out_nxt.result_value = ERR_VALUE;
        if (req_r.op == OP_REQUEST) begin
          if (clash_r) begin
            free_nxt = 1'b0;
            state_nxt = S_IDADV;
          end else if (!free_r) begin
            out_nxt.status = ST_NOSPC;
          end else if ((req_r.id_or_mode[14:9] != '0) ||
                       ((req_r.id_or_mode[8:0] & ~MODE_ALLOWED) != '0) ||
                       req_r.id_or_mode == '0) begin
            out_nxt.status = ST_INVAL;
          end else begin
            d_we = 1'b1;
            d_waddr = free_idx_r;
            d_wdata.id = ctr_r;
            d_wdata.mode = req_r.id_or_mode[8:0];
            d_wdata.owner = req_r.caller_pid;
            d_wdata.group = req_r.caller_group;
            f_we = 1'b1;
            f_waddr = free_idx_r;
            f_wdata = req_r.value;
            hit_idx_nxt = free_idx_r;
            out_nxt.result_value = {17'd0, ctr_r};
          end
        end else if (req_r.op == OP_EXIT) begin
          out_nxt.result_value = '0;
        end else if (req_r.op == OP_READ || req_r.op == OP_WRITE ||
                     req_r.op == OP_SET || req_r.op == OP_CLEAR ||
                     req_r.op == OP_RELEASE) begin
          if (!hit_r || req_r.id_or_mode == '0) begin
            out_nxt.status = ST_INVAL;
          end else if (req_r.op == OP_RELEASE ?
                       (hit_desc_r.owner != req_r.caller_pid) : !perm_ok) begin
            out_nxt.status = ST_ACCES;
          end else begin
            state_nxt = S_FLAGS;
          end
        end else begin
          out_nxt.status = ST_INVAL;
        end
        if (state_nxt == S_DONE) out_v_nxt = 1'b1;
      end
      S_FLAGS: begin
        // Old flags now on the read port; write, set and clear write back the new flags
        out_nxt.result_value = f_rd;
        out_v_nxt = 1'b1;
        state_nxt = S_DONE;
        unique case (req_r.op)
          OP_WRITE: begin f_we = 1'b1; f_wdata = req_r.value; end
          OP_SET:   begin f_we = 1'b1; f_wdata = f_rd | bitmask; end
          OP_CLEAR: begin f_we = 1'b1; f_wdata = f_rd & ~bitmask; end
          OP_RELEASE: begin
            d_we = 1'b1;
            d_waddr = hit_idx_r;
            d_wdata = hit_desc_r;
            d_wdata.id = '0;
            d_wdata.mode = '0;
          end
          default: ;
        endcase
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r <= '0;
      addr_r <= '0;
      rvld_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r <= ctr_nxt;
      addr_r <= addr_nxt;
      rvld_r <= rvld_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_data;
    raddr_r <= raddr_nxt;
    hit_r <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_desc_r <= hit_desc_nxt;
    clash_r <= clash_nxt;
    free_r <= free_nxt;
    free_idx_r <= free_idx_nxt;
    out_r <= out_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data = out_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctr_r < ID_WRAP) else $error("id counter out of range");
  a_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");
endmodule
